/* src/disc_particle_interaction_step_macros.svh */
// Assertion shorthands shared by the disc interaction block.
`ifndef DISC_PARTICLE_INTERACTION_STEP_MACROS_SVH
`define DISC_PARTICLE_INTERACTION_STEP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DPIS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define DPIS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/dpis_pkg.sv */
package dpis_pkg;

  // Word format
  localparam int W = 32;
  localparam int F = 16;

  typedef logic signed [W-1:0] word_t;
  typedef logic [2*W-1:0]      dword_t;
  typedef logic [2*W-F:0]      mag_t;

  localparam word_t WMAX = {1'b0, {(W-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(W-1){1'b0}}};
  localparam word_t ONE  = word_t'(1) <<< F;
  localparam mag_t  MAG_POS = (mag_t'(1) << (W-1)) - mag_t'(1);
  localparam mag_t  MAG_NEG = mag_t'(1) << (W-1);
  localparam logic [2*W:0] HALF_X = (2*W+1)'(1) << (F-1);
  localparam dword_t LIM2 = dword_t'(1000*1000) << (2*F);

  // Operation codes of an input word
  localparam logic [1:0] OP_LOAD     = 2'd0;
  localparam logic [1:0] OP_INTERACT = 2'd1;
  localparam logic [1:0] OP_ADVANCE  = 2'd2;
  localparam logic [1:0] OP_WALL     = 2'd3;

  // Shared unit functions
  localparam logic [1:0] ALU_MUL  = 2'd0;
  localparam logic [1:0] ALU_DIV  = 2'd1;
  localparam logic [1:0] ALU_SQRT = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_STEP   = 3'd0;
  localparam logic [2:0] REG_WLOW   = 3'd1;
  localparam logic [2:0] REG_WHIGH  = 3'd2;
  localparam logic [2:0] REG_MASS   = 3'd3;
  localparam logic [2:0] REG_RADIUS = 3'd4;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_req_t;

  function automatic logic [W-1:0] wmag(word_t v);
    logic [W-1:0] u;
    u = v;
    return v[W-1] ? (~u + W'(1)) : u;
  endfunction

  function automatic word_t sat_add(word_t a, word_t b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return word_t'(s[W-1:0]);
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return word_t'(s[W-1:0]);
  endfunction

  function automatic word_t sat_neg(word_t v);
    return (v == WMIN) ? WMAX : -v;
  endfunction

  // Signed word from a sign and a magnitude, saturated
  function automatic word_t sat_mag(logic neg, mag_t m);
    logic [W-1:0] lo;
    lo = m[W-1:0];
    if (neg) begin
      if (m > MAG_NEG) return WMIN;
      return word_t'(~lo + W'(1));
    end
    if (m > MAG_POS) return WMAX;
    return word_t'(lo);
  endfunction

endpackage

/* src/dpis_alu.sv */
module dpis_alu
  import dpis_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  input  word_t    a_i,
  input  word_t    b_i,
  input  dword_t   v_i,
  output logic     done_o,
  output word_t    res_o,
  output dword_t   raw_o
);

  localparam int CW = $clog2(W+F+1);

  logic [1:0]     mode_r, mode_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic           neg_r, neg_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  dword_t         work_r, work_nxt;
  logic [W+3:0]   rem_r, rem_nxt;
  logic [W+F-1:0] quo_r, quo_nxt;
  logic [W-1:0]   den_r, den_nxt;

  logic [W-1:0]   ma, mb;
  logic [W:0]     dsh;
  logic           dge;
  logic [W+3:0]   ssh, strial;
  logic           sge;
  logic [2*W:0]   prodh;
  logic           drnd, srnd;

  assign ma = wmag(a_i);
  assign mb = wmag(b_i);

  // One restoring step of division and of the root
  always_comb begin
    dsh    = {rem_r[W-1:0], work_r[W+F-1]};
    dge    = dsh >= {1'b0, den_r};
    ssh    = {rem_r[W+1:0], work_r[2*W-1:2*W-2]};
    strial = {2'b00, quo_r[W-1:0], 2'b01};
    sge    = ssh >= strial;
  end

  // Sequence the unit
  always_comb begin
    mode_nxt = mode_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (req.start) begin
      mode_nxt = req.op;
      rem_nxt  = '0;
      quo_nxt  = '0;
      case (req.op)
        ALU_MUL: begin
          work_nxt = ma * mb;
          neg_nxt  = a_i[W-1] ^ b_i[W-1];
          done_nxt = 1'b1;
        end
        ALU_DIV: begin
          work_nxt = dword_t'({ma, {F{1'b0}}});
          den_nxt  = mb;
          neg_nxt  = a_i[W-1] ^ b_i[W-1];
          if (mb == '0) begin
            // zero divisor: saturate by the dividend's sign, or give zero
            quo_nxt  = (ma == '0) ? '0 : '1;
            den_nxt  = W'(1);
            done_nxt = 1'b1;
          end else begin
            cnt_nxt  = CW'(W+F);
            busy_nxt = 1'b1;
          end
        end
        default: begin
          work_nxt = v_i;
          neg_nxt  = 1'b0;
          cnt_nxt  = CW'(W);
          busy_nxt = 1'b1;
        end
      endcase
    end else if (busy_r) begin
      if (mode_r == ALU_DIV) begin
        rem_nxt  = {3'b000, dge ? (dsh - {1'b0, den_r}) : dsh};
        quo_nxt  = {quo_r[W+F-2:0], dge};
        work_nxt = work_r << 1;
      end else begin
        rem_nxt  = sge ? (ssh - strial) : ssh;
        quo_nxt  = {quo_r[W+F-2:0], sge};
        work_nxt = work_r << 2;
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      mode_r <= ALU_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
  end

  // Round and saturate the finished value
  always_comb begin
    prodh = {1'b0, work_r} + HALF_X;
    drnd  = {rem_r[W-1:0], 1'b0} >= {1'b0, den_r};
    srnd  = rem_r > {4'b0000, quo_r[W-1:0]};
    case (mode_r)
      ALU_MUL:  res_o = sat_mag(neg_r, prodh[2*W:F]);
      ALU_DIV:  res_o = sat_mag(neg_r, {1'b0, quo_r} + mag_t'(drnd));
      ALU_SQRT: res_o = sat_mag(1'b0, mag_t'(quo_r[W-1:0]) + mag_t'(srnd));
      default:  res_o = sat_mag(neg_r, prodh[2*W:F]);
    endcase
  end

  assign done_o = done_r;
  assign raw_o  = work_r;

endmodule

/* src/disc_particle_interaction_step.sv */
// Disc particle interaction step.
// Keeps one particle (position, velocity, Q16.16, saturating). An input word
// carries an operation: load the kept state, interact with another particle,
// advance by one time step, or reflect off the square walls. Each input word
// gives exactly one result word with the kept state, the other particle
// after the interaction and the hit flag with the other particle's id.
// Input and result channels use valid/stall; the APB port sets step time,
// walls, own mass and radius; the user is to write it only while the block
// is idle, which the block itself does not enforce. One word is worked at a
// time; in_stall stays high until its result leaves. The next word is taken
// from the idle state that follows. All products, quotients and roots come
// from one shared unit: a 32x32 multiplier, a one-bit-a-cycle divider and a
// one-bit-a-cycle square root.
// Reset restores the registers' defaults and the kept state (origin, unit
// velocity). A stalled result holds its value until taken.
`include "disc_particle_interaction_step_macros.svh"

module disc_particle_interaction_step
  import dpis_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_operation,
  input  word_t         in_pos_x,
  input  word_t         in_pos_y,
  input  word_t         in_vel_x,
  input  word_t         in_vel_y,
  input  word_t         in_other_force,
  input  logic [30:0]   in_other_mass,
  input  logic [15:0]   in_other_id,
  output logic          out_valid,
  input  logic          out_stall,
  output word_t         out_own_x,
  output word_t         out_own_y,
  output word_t         out_own_vx,
  output word_t         out_own_vy,
  output word_t         out_other_x_out,
  output word_t         out_other_y_out,
  output word_t         out_other_vx_out,
  output word_t         out_other_vy_out,
  output logic          out_hit,
  output logic [15:0]   out_hit_id,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_OUT  = 5'd1;
  localparam logic [4:0] S_WALL = 5'd2;
  localparam logic [4:0] S_DXY  = 5'd3;
  localparam logic [4:0] S_SQX  = 5'd4;
  localparam logic [4:0] S_SQY  = 5'd5;
  localparam logic [4:0] S_SPX  = 5'd6;
  localparam logic [4:0] S_SPY  = 5'd7;
  localparam logic [4:0] S_RAD  = 5'd8;
  localparam logic [4:0] S_DEC  = 5'd9;
  localparam logic [4:0] S_DIV1 = 5'd10;
  localparam logic [4:0] S_DIV2 = 5'd11;
  localparam logic [4:0] S_PULL = 5'd12;
  localparam logic [4:0] S_SQRT = 5'd13;
  localparam logic [4:0] S_NX   = 5'd14;
  localparam logic [4:0] S_NY   = 5'd15;
  localparam logic [4:0] S_DOTX = 5'd16;
  localparam logic [4:0] S_DOTY = 5'd17;
  localparam logic [4:0] S_PDIV = 5'd18;
  localparam logic [4:0] S_PMUL = 5'd19;
  localparam logic [4:0] S_PO   = 5'd20;
  localparam logic [4:0] S_PM   = 5'd21;
  localparam logic [4:0] S_OVX  = 5'd22;
  localparam logic [4:0] S_OVY  = 5'd23;
  localparam logic [4:0] S_SVX  = 5'd24;
  localparam logic [4:0] S_SVY  = 5'd25;
  localparam logic [4:0] S_OX   = 5'd26;
  localparam logic [4:0] S_OY   = 5'd27;
  localparam logic [4:0] S_SX   = 5'd28;
  localparam logic [4:0] S_SY   = 5'd29;
  localparam logic [4:0] S_ADVX = 5'd30;
  localparam logic [4:0] S_ADVY = 5'd31;

  // Control and kept state
  logic [4:0]  state_r, state_nxt;
  logic        issued_r, issued_nxt;
  logic [1:0]  op_r, op_nxt;
  word_t       sx_r, sx_nxt, sy_r, sy_nxt, svx_r, svx_nxt, svy_r, svy_nxt;
  logic        hit_r, hit_nxt;
  // Configuration
  logic [W-2:0] step_r, mass_r, rad_r;
  word_t        wlo_r, whi_r;
  // Working payload
  word_t       ox_r, ox_nxt, oy_r, oy_nxt, ovx_r, ovx_nxt, ovy_r, ovy_nxt;
  word_t       of_r, of_nxt;
  logic [W-2:0] om_r, om_nxt;
  logic [15:0] oid_r, oid_nxt, hit_id_r, hit_id_nxt;
  word_t       dx_r, dx_nxt, dy_r, dy_nxt, t_r, t_nxt, s_r, s_nxt;
  word_t       nx_r, nx_nxt, ny_r, ny_nxt, acc_r, acc_nxt, p_r, p_nxt;
  word_t       po_r, po_nxt;
  dword_t      d2_r, d2_nxt, sp_r, sp_nxt, r2_r, r2_nxt;

  // Shared unit
  alu_req_t    alu_req;
  word_t       alu_a, alu_b, alu_res;
  dword_t      alu_raw;
  logic        alu_done, alu_use;

  // Derived values
  logic [2*W:0] d2h;
  word_t        d2w, dt2, msum, mass_w, rad_w, om_w, step_w;
  logic         nonzero, pull_en, col_en;
  word_t        wx1, wx2, wvx1, wvx2, wy1, wy2, wvy1, wvy2;
  logic         cfg_wr;
  logic [W-1:0] msum_u;

  assign mass_w = word_t'({1'b0, mass_r});
  assign rad_w  = word_t'({1'b0, rad_r});
  assign om_w   = word_t'({1'b0, om_r});
  assign step_w = word_t'({1'b0, step_r});

  always_comb begin
    d2h     = {1'b0, d2_r} + HALF_X;
    d2w     = sat_mag(1'b0, d2h[2*W:F]);
    dt2     = step_r[W-2] ? WMAX : word_t'({1'b0, step_r[W-3:0], 1'b0});
    msum_u  = {1'b0, mass_r} + {1'b0, om_r};
    msum    = msum_u[W-1] ? WMAX : word_t'(msum_u);
    nonzero = d2_r != '0;
    pull_en = nonzero && (sp_r < LIM2);
    col_en  = nonzero && ({2'b00, d2_r} < {r2_r, 2'b00});
  end

  // Reflect off the walls, low wall first on each axis
  always_comb begin
    wx1  = (sx_r < wlo_r) ? wlo_r : sx_r;
    wvx1 = (sx_r < wlo_r) ? sat_neg(svx_r) : svx_r;
    wx2  = (wx1 > whi_r) ? whi_r : wx1;
    wvx2 = (wx1 > whi_r) ? sat_neg(wvx1) : wvx1;
    wy1  = (sy_r < wlo_r) ? wlo_r : sy_r;
    wvy1 = (sy_r < wlo_r) ? sat_neg(svy_r) : svy_r;
    wy2  = (wy1 > whi_r) ? whi_r : wy1;
    wvy2 = (wy1 > whi_r) ? sat_neg(wvy1) : wvy1;
  end

  // Pick the shared unit's function and operands
  always_comb begin
    alu_use = state_r inside {S_SQX, S_SQY, S_SPX, S_SPY, S_RAD, S_DIV1, S_DIV2,
                              S_SQRT, S_NX, S_NY, S_DOTX, S_DOTY, S_PDIV, S_PMUL,
                              S_PO, S_PM, S_OVX, S_OVY, S_SVX, S_SVY, S_OX, S_OY,
                              S_SX, S_SY, S_ADVX, S_ADVY};
    alu_req.op = ALU_MUL;
    alu_a      = '0;
    alu_b      = '0;
    case (state_r)
      S_SQX:  begin alu_a = dx_r;  alu_b = dx_r;  end
      S_SQY:  begin alu_a = dy_r;  alu_b = dy_r;  end
      S_SPX:  begin alu_a = svx_r; alu_b = svx_r; end
      S_SPY:  begin alu_a = svy_r; alu_b = svy_r; end
      S_RAD:  begin alu_a = rad_w; alu_b = rad_w; end
      S_DIV1: begin alu_req.op = ALU_DIV; alu_a = of_r; alu_b = d2w; end
      S_DIV2: begin alu_req.op = ALU_DIV; alu_a = t_r;  alu_b = mass_w; end
      S_SQRT: alu_req.op = ALU_SQRT;
      S_NX:   begin alu_req.op = ALU_DIV; alu_a = dx_r; alu_b = s_r; end
      S_NY:   begin alu_req.op = ALU_DIV; alu_a = dy_r; alu_b = s_r; end
      S_DOTX: begin alu_a = sat_sub(svx_r, ovx_r); alu_b = nx_r; end
      S_DOTY: begin alu_a = sat_sub(svy_r, ovy_r); alu_b = ny_r; end
      S_PDIV: begin alu_req.op = ALU_DIV; alu_a = ONE <<< 1; alu_b = msum; end
      S_PMUL: begin alu_a = p_r;   alu_b = acc_r;  end
      S_PO:   begin alu_a = p_r;   alu_b = om_w;   end
      S_PM:   begin alu_a = p_r;   alu_b = mass_w; end
      S_OVX:  begin alu_a = acc_r; alu_b = nx_r;   end
      S_OVY:  begin alu_a = acc_r; alu_b = ny_r;   end
      S_SVX:  begin alu_a = po_r;  alu_b = nx_r;   end
      S_SVY:  begin alu_a = po_r;  alu_b = ny_r;   end
      S_OX:   begin alu_a = ovx_r; alu_b = dt2;    end
      S_OY:   begin alu_a = ovy_r; alu_b = dt2;    end
      S_SX:   begin alu_a = svx_r; alu_b = dt2;    end
      S_SY:   begin alu_a = svy_r; alu_b = dt2;    end
      S_ADVX: begin alu_a = svx_r; alu_b = step_w; end
      S_ADVY: begin alu_a = svy_r; alu_b = step_w; end
      default: ;
    endcase
    alu_req.start = alu_use && !issued_r;
  end

  dpis_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .v_i    (d2_r),
    .done_o (alu_done),
    .res_o  (alu_res),
    .raw_o  (alu_raw)
  );

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    issued_nxt = alu_done ? 1'b0 : (alu_req.start ? 1'b1 : issued_r);
    op_nxt     = op_r;
    sx_nxt = sx_r;   sy_nxt = sy_r;   svx_nxt = svx_r; svy_nxt = svy_r;
    ox_nxt = ox_r;   oy_nxt = oy_r;   ovx_nxt = ovx_r; ovy_nxt = ovy_r;
    of_nxt = of_r;   om_nxt = om_r;   oid_nxt = oid_r;
    hit_nxt = hit_r; hit_id_nxt = hit_id_r;
    dx_nxt = dx_r;   dy_nxt = dy_r;   t_nxt = t_r;     s_nxt = s_r;
    nx_nxt = nx_r;   ny_nxt = ny_r;   acc_nxt = acc_r; p_nxt = p_r;
    po_nxt = po_r;   d2_nxt = d2_r;   sp_nxt = sp_r;   r2_nxt = r2_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_operation;
          hit_nxt    = 1'b0;
          hit_id_nxt = '0;
          ox_nxt = '0; oy_nxt = '0; ovx_nxt = '0; ovy_nxt = '0;
          case (in_operation)
            OP_LOAD: begin
              sx_nxt  = in_pos_x; sy_nxt  = in_pos_y;
              svx_nxt = in_vel_x; svy_nxt = in_vel_y;
              state_nxt = S_OUT;
            end
            OP_INTERACT: begin
              ox_nxt  = in_pos_x; oy_nxt  = in_pos_y;
              ovx_nxt = in_vel_x; ovy_nxt = in_vel_y;
              of_nxt  = in_other_force;
              om_nxt  = in_other_mass;
              oid_nxt = in_other_id;
              state_nxt = S_DXY;
            end
            OP_ADVANCE: state_nxt = S_ADVX;
            default:    state_nxt = S_WALL;
          endcase
        end
      end
      S_WALL: begin
        sx_nxt = wx2; svx_nxt = wvx2; sy_nxt = wy2; svy_nxt = wvy2;
        state_nxt = S_OUT;
      end
      S_DXY: begin
        dx_nxt = sat_sub(ox_r, sx_r);
        dy_nxt = sat_sub(oy_r, sy_r);
        state_nxt = S_SQX;
      end
      S_DEC: begin
        if (pull_en)     state_nxt = S_DIV1;
        else if (col_en) state_nxt = S_SQRT;
        else             state_nxt = S_OUT;
      end
      S_PULL: begin
        svy_nxt = (sy_r > oy_r) ? sat_sub(svy_r, t_r) : sat_add(svy_r, t_r);
        svx_nxt = (sx_r > ox_r) ? sat_sub(svx_r, t_r) : sat_add(svx_r, t_r);
        state_nxt = col_en ? S_SQRT : S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: begin
        if (alu_done) begin
          case (state_r)
            S_SQX:  begin d2_nxt = alu_raw;          state_nxt = S_SQY;  end
            S_SQY:  begin d2_nxt = d2_r + alu_raw;   state_nxt = S_SPX;  end
            S_SPX:  begin sp_nxt = alu_raw;          state_nxt = S_SPY;  end
            S_SPY:  begin sp_nxt = sp_r + alu_raw;   state_nxt = S_RAD;  end
            S_RAD:  begin r2_nxt = alu_raw;          state_nxt = S_DEC;  end
            S_DIV1: begin t_nxt = alu_res;           state_nxt = S_DIV2; end
            S_DIV2: begin t_nxt = alu_res;           state_nxt = S_PULL; end
            S_SQRT: begin s_nxt = alu_res;           state_nxt = S_NX;   end
            S_NX:   begin nx_nxt = alu_res;          state_nxt = S_NY;   end
            S_NY:   begin ny_nxt = alu_res;          state_nxt = S_DOTX; end
            S_DOTX: begin acc_nxt = alu_res;         state_nxt = S_DOTY; end
            S_DOTY: begin
              acc_nxt = sat_add(acc_r, alu_res);
              state_nxt = S_PDIV;
            end
            S_PDIV: begin p_nxt = alu_res;           state_nxt = S_PMUL; end
            S_PMUL: begin p_nxt = alu_res;           state_nxt = S_PO;   end
            S_PO:   begin po_nxt = alu_res;          state_nxt = S_PM;   end
            S_PM:   begin acc_nxt = alu_res;         state_nxt = S_OVX;  end
            S_OVX:  begin ovx_nxt = sat_add(ovx_r, alu_res); state_nxt = S_OVY; end
            S_OVY:  begin ovy_nxt = sat_add(ovy_r, alu_res); state_nxt = S_SVX; end
            S_SVX:  begin svx_nxt = sat_sub(svx_r, alu_res); state_nxt = S_SVY; end
            S_SVY:  begin svy_nxt = sat_sub(svy_r, alu_res); state_nxt = S_OX;  end
            S_OX:   begin ox_nxt = sat_add(ox_r, alu_res);   state_nxt = S_OY;  end
            S_OY:   begin oy_nxt = sat_add(oy_r, alu_res);   state_nxt = S_SX;  end
            S_SX:   begin sx_nxt = sat_add(sx_r, alu_res);   state_nxt = S_SY;  end
            S_SY: begin
              sy_nxt     = sat_add(sy_r, alu_res);
              hit_nxt    = 1'b1;
              hit_id_nxt = oid_r;
              state_nxt  = S_OUT;
            end
            S_ADVX: begin sx_nxt = sat_add(sx_r, alu_res); state_nxt = S_ADVY; end
            S_ADVY: begin sy_nxt = sat_add(sy_r, alu_res); state_nxt = S_OUT;  end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
    endcase
  end

  // Control, kept state and registers
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      issued_r <= 1'b0;
      op_r     <= OP_LOAD;
      hit_r    <= 1'b0;
      sx_r     <= '0;
      sy_r     <= '0;
      svx_r    <= ONE;
      svy_r    <= ONE;
      step_r   <= (W-1)'(655);
      wlo_r    <= '0;
      whi_r    <= word_t'(6553600);
      mass_r   <= (W-1)'(131072);
      rad_r    <= (W-1)'(13107);
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
      op_r     <= op_nxt;
      hit_r    <= hit_nxt;
      sx_r     <= sx_nxt;
      sy_r     <= sy_nxt;
      svx_r    <= svx_nxt;
      svy_r    <= svy_nxt;
      if (cfg_wr) begin
        case (paddr[4:2])
          REG_STEP:   step_r <= pwdata[W-2:0];
          REG_WLOW:   wlo_r  <= word_t'(pwdata);
          REG_WHIGH:  whi_r  <= word_t'(pwdata);
          REG_MASS:   mass_r <= pwdata[W-2:0];
          REG_RADIUS: rad_r  <= pwdata[W-2:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ox_r <= ox_nxt;   oy_r <= oy_nxt;   ovx_r <= ovx_nxt; ovy_r <= ovy_nxt;
    of_r <= of_nxt;   om_r <= om_nxt;   oid_r <= oid_nxt; hit_id_r <= hit_id_nxt;
    dx_r <= dx_nxt;   dy_r <= dy_nxt;   t_r <= t_nxt;     s_r <= s_nxt;
    nx_r <= nx_nxt;   ny_r <= ny_nxt;   acc_r <= acc_nxt; p_r <= p_nxt;
    po_r <= po_nxt;   d2_r <= d2_nxt;   sp_r <= sp_nxt;   r2_r <= r2_nxt;
  end

  // Register read back
  always_comb begin
    case (paddr[4:2])
      REG_STEP:   prdata = {1'b0, step_r};
      REG_WLOW:   prdata = wlo_r;
      REG_WHIGH:  prdata = whi_r;
      REG_MASS:   prdata = {1'b0, mass_r};
      REG_RADIUS: prdata = {1'b0, rad_r};
      default:    prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  // Channels and result word
  assign in_stall         = state_r != S_IDLE;
  assign out_valid        = state_r == S_OUT;
  assign out_own_x        = sx_r;
  assign out_own_y        = sy_r;
  assign out_own_vx       = svx_r;
  assign out_own_vy       = svy_r;
  assign out_other_x_out  = ox_r;
  assign out_other_y_out  = oy_r;
  assign out_other_vx_out = ovx_r;
  assign out_other_vy_out = ovy_r;
  assign out_hit          = hit_r;
  assign out_hit_id       = hit_id_r;

  // Checks
  `DPIS_ASSERT_IMP(a_out_busy, out_valid, in_stall, "result shown while accepting")
  `DPIS_ASSERT_IMP(a_done_issued, alu_done, issued_r, "unit finished without a request")
  `DPIS_ASSERT_IMP(a_hit_op, out_valid && out_hit, op_r == OP_INTERACT, "hit outside interact")
  `DPIS_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, in_stall, "accepted word not held")

endmodule

/* dv/disc_particle_interaction_step_tb.sv */
module disc_particle_interaction_step_tb;
  import dpis_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [127:0] u128_t;

  typedef struct {
    logic [1:0]  op;
    word_t       px;
    word_t       py;
    word_t       vx;
    word_t       vy;
    word_t       force_f;
    logic [30:0] mass;
    logic [15:0] id;
  } step_word_t;

  typedef struct {
    word_t       own_x;
    word_t       own_y;
    word_t       own_vx;
    word_t       own_vy;
    word_t       oth_x;
    word_t       oth_y;
    word_t       oth_vx;
    word_t       oth_vy;
    logic        hit;
    logic [15:0] hit_id;
  } step_result_t;

  localparam longint LMAX = 64'sd2147483647;
  localparam longint LMIN = -64'sd2147483648;

  // Fixed-point particle predictor and the queue of predicted result words
  class disc_scoreboard;
    longint kx, ky, kvx, kvy;
    longint dt, wlo, whi, kmass, krad;
    step_result_t pending_q[$];
    int errors;

    function new();
      kx = 0; ky = 0; kvx = 65536; kvy = 65536;
      dt = 655; wlo = 0; whi = 6553600; kmass = 131072; krad = 13107;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_STEP:   dt = longint'(value[30:0]);
        REG_WLOW:   wlo = longint'(signed'(value));
        REG_WHIGH:  whi = longint'(signed'(value));
        REG_MASS:   kmass = longint'(value[30:0]);
        REG_RADIUS: krad = longint'(value[30:0]);
        default: ;
      endcase
    endfunction

    function longint clamp(longint v);
      return v > LMAX ? LMAX : (v < LMIN ? LMIN : v);
    endfunction

    function u128_t magn(longint v);
      return v < 0 ? u128_t'(-v) : u128_t'(v);
    endfunction

    function longint from_mag(bit neg, u128_t m);
      if (neg) return m > 128'd2147483648 ? LMIN : -longint'(m[63:0]);
      return m > 128'd2147483647 ? LMAX : longint'(m[63:0]);
    endfunction

    function longint fmul(longint a, longint b);
      return from_mag((a < 0) != (b < 0), (magn(a) * magn(b) + 128'd32768) >> 16);
    endfunction

    function longint fdiv(longint a, longint b);
      u128_t d, n, q, r;
      if (b == 0) return a == 0 ? 0 : (a < 0 ? LMIN : LMAX);
      d = magn(b);
      n = magn(a) << 16;
      q = n / d;
      r = n - q * d;
      if (r >= d - r) q = q + 1;
      return from_mag((a < 0) != (b < 0), q);
    endfunction

    function longint root(u128_t v);
      u128_t lo, cand;
      lo = 0;
      for (int b = 49; b >= 0; b--) begin
        cand = lo | (u128_t'(1) << b);
        if (cand * cand <= v) lo = cand;
      end
      if (v > lo * lo + lo) lo = lo + 1;
      return from_mag(1'b0, lo);
    endfunction

    // Predict the result of one accepted word and advance the kept particle
    function void note_input(step_word_t w);
      step_result_t e;
      longint ox, oy, ovx, ovy, dx, dy, t, s, nx, ny, dot, p, po, pm, dt2;
      u128_t d2, sp, lim, diam;
      ox = w.px; oy = w.py; ovx = w.vx; ovy = w.vy;
      e.oth_x = 0; e.oth_y = 0; e.oth_vx = 0; e.oth_vy = 0;
      e.hit = 0; e.hit_id = 0;
      case (w.op)
        OP_LOAD: begin
          kx = ox; ky = oy; kvx = ovx; kvy = ovy;
        end
        OP_INTERACT: begin
          dx = clamp(ox - kx);
          dy = clamp(oy - ky);
          d2 = magn(dx) * magn(dx) + magn(dy) * magn(dy);
          sp = magn(kvx) * magn(kvx) + magn(kvy) * magn(kvy);
          lim = u128_t'(1000) << 16;
          diam = u128_t'(2 * krad);
          if (d2 != 0 && sp < lim * lim) begin
            t = fdiv(fdiv(w.force_f, from_mag(1'b0, (d2 + 128'd32768) >> 16)), kmass);
            kvy = clamp(ky > oy ? kvy - t : kvy + t);
            kvx = clamp(kx > ox ? kvx - t : kvx + t);
          end
          if (d2 != 0 && d2 < diam * diam) begin
            s = root(d2);
            nx = fdiv(dx, s);
            ny = fdiv(dy, s);
            dot = clamp(fmul(clamp(kvx - ovx), nx) + fmul(clamp(kvy - ovy), ny));
            p = fmul(fdiv(131072, clamp(kmass + longint'(w.mass))), dot);
            po = fmul(p, longint'(w.mass));
            pm = fmul(p, kmass);
            dt2 = clamp(2 * dt);
            ovx = clamp(ovx + fmul(pm, nx));
            ovy = clamp(ovy + fmul(pm, ny));
            kvx = clamp(kvx - fmul(po, nx));
            kvy = clamp(kvy - fmul(po, ny));
            ox = clamp(ox + fmul(ovx, dt2));
            oy = clamp(oy + fmul(ovy, dt2));
            kx = clamp(kx + fmul(kvx, dt2));
            ky = clamp(ky + fmul(kvy, dt2));
            e.hit = 1;
            e.hit_id = w.id;
          end
          e.oth_x = word_t'(ox); e.oth_y = word_t'(oy);
          e.oth_vx = word_t'(ovx); e.oth_vy = word_t'(ovy);
        end
        OP_ADVANCE: begin
          kx = clamp(kx + fmul(kvx, dt));
          ky = clamp(ky + fmul(kvy, dt));
        end
        default: begin
          // low wall first, so crossed walls end at the high one
          if (kx < wlo) begin kvx = clamp(-kvx); kx = wlo; end
          if (kx > whi) begin kvx = clamp(-kvx); kx = whi; end
          if (ky < wlo) begin kvy = clamp(-kvy); ky = wlo; end
          if (ky > whi) begin kvy = clamp(-kvy); ky = whi; end
        end
      endcase
      e.own_x = word_t'(kx); e.own_y = word_t'(ky);
      e.own_vx = word_t'(kvx); e.own_vy = word_t'(kvy);
      pending_q.insert(pending_q.size(), e);
    endfunction

    function void cmp(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(step_result_t a);
      step_result_t e;
      if (pending_q.size() == 0) begin
        $error("result word with nothing predicted");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      cmp("own_x", e.own_x, a.own_x);
      cmp("own_y", e.own_y, a.own_y);
      cmp("own_vx", e.own_vx, a.own_vx);
      cmp("own_vy", e.own_vy, a.own_vy);
      cmp("other_x_out", e.oth_x, a.oth_x);
      cmp("other_y_out", e.oth_y, a.oth_y);
      cmp("other_vx_out", e.oth_vx, a.oth_vx);
      cmp("other_vy_out", e.oth_vy, a.oth_vy);
      cmp("hit", e.hit, a.hit);
      cmp("hit_id", e.hit_id, a.hit_id);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  in_operation = OP_LOAD;
  word_t       in_pos_x = 0, in_pos_y = 0, in_vel_x = 0, in_vel_y = 0;
  word_t       in_other_force = 0;
  logic [30:0] in_other_mass = 31'd1;
  logic [15:0] in_other_id = 0;
  logic        out_valid;
  logic        out_stall = 0;
  word_t       out_own_x, out_own_y, out_own_vx, out_own_vy;
  word_t       out_other_x_out, out_other_y_out, out_other_vx_out, out_other_vy_out;
  logic        out_hit;
  logic [15:0] out_hit_id;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  disc_scoreboard sb = new();
  bit long_hold = 0;

  disc_particle_interaction_step i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Register write: setup cycle, then access cycle
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_word(step_word_t w, int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1;
    in_operation <= w.op; in_pos_x <= w.px; in_pos_y <= w.py;
    in_vel_x <= w.vx; in_vel_y <= w.vy; in_other_force <= w.force_f;
    in_other_mass <= w.mass; in_other_id <= w.id;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
  endtask

  task automatic idle_sender();
    @(negedge clk);
    in_valid <= 0;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic word_t rnd_full();
    return word_t'($urandom);
  endfunction

  function automatic word_t rnd_near(longint base, int spread);
    return word_t'(sb.clamp(base + $signed($urandom_range(0, 2 * spread)) - spread));
  endfunction

  function automatic step_word_t rnd_word();
    step_word_t w;
    int r;
    r = $urandom_range(0, 99);
    w.force_f = $urandom_range(0, 3) == 0 ? rnd_full()
              : word_t'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    w.mass = $urandom_range(0, 5) == 0 ? 31'($urandom) | 31'd1
           : 31'($urandom_range(1 << 12, 1 << 20));
    w.id = 16'($urandom);
    if (r < 15) begin
      w.op = OP_LOAD;
      if ($urandom_range(0, 4) == 0) begin
        w.px = rnd_full(); w.py = rnd_full(); w.vx = rnd_full(); w.vy = rnd_full();
      end else begin
        w.px = word_t'($urandom_range(0, 120 << 16)) - (10 << 16);
        w.py = word_t'($urandom_range(0, 120 << 16)) - (10 << 16);
        w.vx = rnd_near(0, 1 << 20);
        w.vy = rnd_near(0, 1 << 20);
      end
    end else if (r < 60) begin
      // close approach: offsets inside the disc diameter most of the time
      w.op = OP_INTERACT;
      w.px = rnd_near(sb.kx, 24000);
      w.py = rnd_near(sb.ky, 24000);
      if ($urandom_range(0, 9) == 0) w.py = word_t'(sb.ky);
      if ($urandom_range(0, 9) == 0) w.px = word_t'(sb.kx);
      w.vx = rnd_near(0, 1 << 20);
      w.vy = rnd_near(0, 1 << 20);
    end else if (r < 70) begin
      w.op = OP_INTERACT;
      w.px = rnd_full(); w.py = rnd_full(); w.vx = rnd_full(); w.vy = rnd_full();
    end else begin
      w.op = r < 85 ? OP_ADVANCE : OP_WALL;
      w.px = rnd_full(); w.py = rnd_full(); w.vx = rnd_full(); w.vy = rnd_full();
    end
    return w;
  endfunction

  task automatic send_op(logic [1:0] op, word_t px, word_t py, word_t vx, word_t vy,
                         word_t ff, logic [30:0] m, logic [15:0] id);
    step_word_t w;
    w.op = op; w.px = px; w.py = py; w.vx = vx; w.vy = vy;
    w.force_f = ff; w.mass = m; w.id = id;
    send_word(w, pick_gap());
  endtask

  // Wait until every predicted result word has been taken
  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // Result side: random stall, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1;
        repeat (300) @(negedge clk);
        long_hold = 0;
      end else if ($urandom_range(0, 99) < 40) begin
        out_stall <= 1;
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40)
                                          : $urandom_range(0, 3)) @(negedge clk);
      end else begin
        out_stall <= 0;
        repeat ($urandom_range(0, 20)) @(negedge clk);
      end
    end
  end

  // Take accepted result words
  always @(posedge clk) begin
    step_result_t a;
    if (rst_n && out_valid && !out_stall) begin
      a.own_x = out_own_x; a.own_y = out_own_y;
      a.own_vx = out_own_vx; a.own_vy = out_own_vy;
      a.oth_x = out_other_x_out; a.oth_y = out_other_y_out;
      a.oth_vx = out_other_vx_out; a.oth_vy = out_other_vy_out;
      a.hit = out_hit; a.hit_id = out_hit_id;
      sb.check_result(a);
    end
  end

  initial begin
    #30ms;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [31:0] phase_cfg [6][5];
    phase_cfg = '{
      '{32'd655, 32'd0, 32'd6553600, 32'd131072, 32'd13107},
      '{32'd0, 32'h8000_0000, 32'h7fff_ffff, 32'd1, 32'd0},
      '{32'h7fff_ffff, 32'd6553600, 32'd0, 32'h7fff_ffff, 32'h7fff_ffff},
      '{32'd65536, 32'hffec_0000, 32'd1310720, 32'd65536, 32'd26214},
      '{32'd3277, 32'd655360, 32'd5242880, 32'd1000, 32'd20000},
      '{32'd655, 32'd0, 32'd6553600, 32'd131072, 32'd13107}};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed words at reset settings
    send_op(OP_ADVANCE, 0, 0, 0, 0, 0, 31'd1, 0);
    send_op(OP_INTERACT, 0, 0, 0, 0, 32'sd65536, 31'd65536, 16'd7);
    send_op(OP_INTERACT, 32'sd10000, 0, -32'sd65536, 0, 32'sd65536, 31'd65536, 16'hffff);
    send_op(OP_INTERACT, 0, 32'sd8000, 0, 0, -32'sd100000, 31'h7fffffff, 16'd1);
    send_op(OP_LOAD, WMIN, WMAX, WMAX, WMIN, 0, 31'd1, 0);
    send_op(OP_WALL, 0, 0, 0, 0, 0, 31'd1, 0);
    send_op(OP_LOAD, WMAX, WMIN, WMIN, WMAX, 0, 31'd1, 0);
    send_op(OP_ADVANCE, 0, 0, 0, 0, 0, 31'd1, 0);
    send_op(OP_INTERACT, WMIN, WMAX, WMIN, WMAX, WMIN, 31'd1, 16'hffff);
    send_op(OP_WALL, 0, 0, 0, 0, 0, 31'd1, 0);
    send_op(OP_LOAD, 32'sd65536, 32'sd65536, 32'sd1000 << 16, 0, 0, 31'd1, 0);
    send_op(OP_INTERACT, 32'sd70000, 32'sd65536, 0, 0, WMAX, 31'd65536, 16'd3);
    send_op(OP_LOAD, 32'sd65536, 32'sd65536, 32'sd999 << 16, 0, 0, 31'd1, 0);
    send_op(OP_INTERACT, 32'sd65536, 32'sd60000, 0, 0, WMAX, 31'd65536, 16'd4);
    send_op(OP_LOAD, -32'sd65536, 32'sd200 << 16, 32'sd65536, -32'sd65536, 0, 31'd1, 0);
    send_op(OP_WALL, 0, 0, 0, 0, 0, 31'd1, 0);
    send_op(OP_INTERACT, WMAX, WMAX, WMAX, WMAX, WMAX, 31'h7fffffff, 16'hffff);

    for (int ph = 0; ph < 6; ph++) begin
      // drop valid before waiting so the last word is not taken twice
      idle_sender();
      drain();
      for (int k = 0; k < 5; k++) write_reg(3'(k), phase_cfg[ph][k]);
      if (ph == 2) long_hold = 1;
      for (int n = 0; n < 250; n++) begin
        if (ph == 3 && n == 100) begin
          idle_sender();
          drain();
        end
        send_word(rnd_word(), pick_gap());
      end
    end
    idle_sender();

    drain();
    repeat (400) @(posedge clk);
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
